/* hw/rtl/smsd_pkg.sv */
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared types and constants for the sliding median spike detector: the
// contents of one cell of the sorted chain and the control and status words
// that pass between the top level and the chain.
// ----------------------------------------------------------------------------
package smsd_pkg;

  // Number of cells in the chain, which is also the longest window.
  localparam int WINDOW_MAX  = 256;
  localparam int VAL_W       = 8;
  localparam int AGE_W       = 8;
  localparam int LEN_W       = 9;
  localparam int DBL_W       = 9;
  localparam int CNT_W       = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // One window entry: its value and how many samples have come in after it.
  typedef struct packed {
    logic             occ;
    logic [VAL_W-1:0] val;
    logic [AGE_W-1:0] age;
  } cell_t;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic             load;     // a sample word is accepted this cycle
    logic             clear;    // empty the window
    logic             full;     // the window is full, so the oldest leaves
    logic [VAL_W-1:0] new_val;  // the sample that enters
    logic [AGE_W-1:0] old_age;  // age of the oldest entry when full
    logic [VAL_W-1:0] hi_idx;   // cell holding the upper middle value
    logic [VAL_W-1:0] lo_idx;   // cell holding the lower middle value
  } chain_ctrl_t;

  // Middle values of the window as it stands before the update.
  typedef struct packed {
    logic [VAL_W-1:0] med_hi;
    logic [VAL_W-1:0] med_lo;
  } chain_stat_t;

endpackage

/* hw/rtl/smsd_cell.sv */
// ----------------------------------------------------------------------------
// smsd_cell
// One cell of the sorted window chain. The chain keeps entries in ascending
// order of value, and among equal values in ascending order of age. On each
// accepted word the cell first closes the gap left by the oldest entry, then
// opens a gap for the new sample, using only its own entry and its neighbors.
// ----------------------------------------------------------------------------
module smsd_cell
  import smsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  chain_ctrl_t      ctrl,
  input  logic [VAL_W-1:0] old_val,   // value of the entry that leaves
  input  cell_t            right_a,   // entry held by the right neighbor
  input  cell_t            left_b,    // left neighbor after removal
  input  logic             left_gb,   // left neighbor sorts after the sample
  output cell_t            a,         // entry held by this cell
  output logic             rm,        // this entry is the oldest and leaves
  output cell_t            b,         // this cell after removal
  output logic             gb         // this cell sorts after the sample
);

  cell_t a_next;
  cell_t aged_b;
  cell_t aged_left;
  cell_t fresh;
  logic  shift_left;

  // The oldest entry carries the largest age, so it is last among its equals.
  assign rm         = ctrl.full && a.occ && (a.age == ctrl.old_age);
  assign shift_left = ctrl.full && a.occ && ((a.val > old_val) || rm);

  // Window with the oldest entry taken out.
  assign b  = shift_left ? right_a : a;
  assign gb = !b.occ || (b.val >= ctrl.new_val);

  // Ages move on by one for every entry that stays.
  always_comb begin
    aged_b        = b;
    aged_b.age    = b.age + AGE_W'(1);
    aged_left     = left_b;
    aged_left.age = left_b.age + AGE_W'(1);
    fresh.occ     = 1'b1;
    fresh.val     = ctrl.new_val;
    fresh.age     = '0;
  end

  // Insert the sample in front of the first entry that sorts after it.
  always_comb begin
    a_next = a;
    if (ctrl.clear) begin
      a_next.occ = 1'b0;
    end else if (ctrl.load) begin
      if (gb && left_gb) begin
        a_next = aged_left;
      end else if (gb) begin
        a_next = fresh;
      end else begin
        a_next = aged_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a.occ <= 1'b0;
    end else begin
      a.occ <= a_next.occ;
    end
    a.val <= a_next.val;
    a.age <= a_next.age;
  end

endmodule

/* hw/rtl/smsd_chain.sv */
// ----------------------------------------------------------------------------
// smsd_chain
// The row of window cells. It links each cell to its neighbors, finds the
// value of the entry that leaves, and picks out the middle values of the
// window for the median.
// ----------------------------------------------------------------------------
module smsd_chain
  import smsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  output chain_stat_t stat
);

  cell_t            a  [WINDOW_MAX];
  cell_t            b  [WINDOW_MAX];
  logic             gb [WINDOW_MAX];
  logic             rm [WINDOW_MAX];
  logic [VAL_W-1:0] old_val;
  cell_t            empty_cell;

  assign empty_cell = '0;

  // Value of the leaving entry: exactly one cell flags itself when full.
  always_comb begin
    old_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      old_val = old_val | (rm[i] ? a[i].val : '0);
    end
  end

  // Middle values, each taken from the cell at its rank.
  always_comb begin
    stat = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      stat.med_hi = stat.med_hi | ((ctrl.hi_idx == VAL_W'(i)) ? a[i].val : '0);
      stat.med_lo = stat.med_lo | ((ctrl.lo_idx == VAL_W'(i)) ? a[i].val : '0);
    end
  end

  // Row of cells, each wired to its left and right neighbors.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_t right_a;
    cell_t left_b;
    logic  left_gb;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_a = empty_cell;
    end else begin : g_mid
      assign right_a = a[i+1];
    end

    if (i == 0) begin : g_first
      assign left_b  = empty_cell;
      assign left_gb = 1'b0;
    end else begin : g_rest
      assign left_b  = b[i-1];
      assign left_gb = gb[i-1];
    end

    smsd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .old_val (old_val),
      .right_a (right_a),
      .left_b  (left_b),
      .left_gb (left_gb),
      .a       (a[i]),
      .rm      (rm[i]),
      .b       (b[i]),
      .gb      (gb[i])
    );
  end

endmodule

/* hw/rtl/sliding_median_spike_detector.sv */
// ----------------------------------------------------------------------------
// sliding_median_spike_detector
// The block takes one sample word per clock cycle and returns one result
// word for each, in the cycle after the sample is accepted, from an output
// register. A new sample is taken only when that register is empty or its
// word is taken in the same cycle, so while a result waits the input stalls.
// With out_ready held high and cfg_valid low the block takes one sample
// per cycle. The window lives in a sorted chain of 256 cells; removal of
// the oldest entry, the median lookup, the compare and the insertion of the
// new sample all finish in the cycle the sample is accepted, so the rate is
// set by that single chain update. Writing window_length empties the window.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector
  import smsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Configuration channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] window_length,
  // Sample channel.
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] sample_value,
  // Result channel.
  output logic             out_valid,
  input  logic             out_ready,
  output logic             alert,
  output logic             window_full,
  output logic [DBL_W-1:0] median_doubled,
  output logic [CNT_W-1:0] alert_count
);

  logic [LEN_W-1:0] len_reg;
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] eff_len;
  logic [VAL_W-1:0] half;
  logic             full;
  logic             load;
  logic             cfg_load;
  logic             hit;
  logic [DBL_W-1:0] ref_dbl;
  logic [CNT_W-1:0] count_next;
  chain_ctrl_t      ctrl;
  chain_stat_t      stat;

  assign cfg_ready = 1'b1;
  assign cfg_load  = cfg_valid && cfg_ready;
  assign in_ready  = (!out_valid || out_ready) && !cfg_valid;
  assign load      = in_valid && in_ready;

  // Window length as used: zero counts as one, long values are clipped.
  always_comb begin
    if (len_reg == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_reg > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = len_reg;
    end
  end

  assign half = eff_len[LEN_W-1:1];
  assign full = (fill >= eff_len);

  // Chain control for this cycle.
  always_comb begin
    ctrl.load    = load;
    ctrl.clear   = cfg_load;
    ctrl.full    = full;
    ctrl.new_val = sample_value;
    ctrl.old_age = AGE_W'(eff_len - LEN_W'(1));
    ctrl.hi_idx  = half;
    ctrl.lo_idx  = half - VAL_W'(1);
  end

  smsd_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // Twice the median (zero until full): double one middle value or add two.
  always_comb begin
    if (!full) begin
      ref_dbl = '0;
    end else if (eff_len[0]) begin
      ref_dbl = {stat.med_hi, 1'b0};
    end else begin
      ref_dbl = DBL_W'(stat.med_hi) + DBL_W'(stat.med_lo);
    end
  end

  assign hit = full && (DBL_W'(sample_value) >= ref_dbl);

  always_comb begin
    count_next = alert_count;
    if (hit && (alert_count != CNT_MAX)) begin
      count_next = alert_count + CNT_W'(1);
    end
  end

  // Window length, fill level and the alert counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg     <= LEN_W'(5);
      fill        <= '0;
      alert_count <= '0;
    end else if (cfg_load) begin
      len_reg <= window_length;
      fill    <= '0;
    end else if (load) begin
      alert_count <= count_next;
      if (!full) begin
        fill <= fill + LEN_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      alert          <= hit;
      window_full    <= full;
      median_doubled <= ref_dbl;
    end
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding median spike detector. A short table
// of directed words is followed by random phases under several window
// lengths. Both channels stall at random. Each result word is checked, in
// order, against a histogram-based model of the window or a pinned word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smsd_pkg::*;

  localparam int BINS        = 1 << VAL_W;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_AFTER  = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int N_ROWS      = 25;
  localparam int N_PHASES    = 7;

  // One result word as the block returns it.
  typedef struct packed {
    logic             alert;
    logic             full;
    logic [DBL_W-1:0] med2;
    logic [CNT_W-1:0] count;
  } spike_word_t;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  // One line of the directed table; pinned rows carry a typed-in result.
  typedef struct packed {
    row_kind_t        kind;
    logic [LEN_W-1:0] value;
    logic             pinned;
    spike_word_t      word;
  } row_t;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] window_length;
  logic             in_valid;
  logic             in_ready;
  logic [VAL_W-1:0] sample_value;
  logic             out_valid;
  logic             out_ready;
  logic             alert;
  logic             window_full;
  logic [DBL_W-1:0] median_doubled;
  logic [CNT_W-1:0] alert_count;

  // Sideband that travels with each sample word: a typed-in expectation.
  logic        pin_on;
  spike_word_t pin_word;
  bit          quiet;

  // Model of the window: histogram, ring of recent samples and counters.
  logic [8:0]       bin_count [BINS];
  logic [VAL_W-1:0] ring [WINDOW_MAX];
  int unsigned      ring_pos;
  int unsigned      fill;
  logic [CNT_W-1:0] alerts;
  logic [LEN_W-1:0] len_reg;

  spike_word_t expected_words [$];
  int          stall_cycles;
  int          mismatches;
  row_t        script [N_ROWS];

  sliding_median_spike_detector dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_length  (window_length),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alert          (alert),
    .window_full    (window_full),
    .median_doubled (median_doubled),
    .alert_count    (alert_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Empty the window; the alert counter is kept.
  task automatic window_clear();
    for (int i = 0; i < BINS; i++) bin_count[i] = '0;
    ring_pos = 0;
    fill     = 0;
  endtask

  function automatic int unsigned active_length();
    if (len_reg == 0) return 1;
    if (len_reg > LEN_MAX) return WINDOW_MAX;
    return len_reg;
  endfunction

  // Sum of the two middle values, or twice the middle value for odd windows.
  function automatic logic [DBL_W-1:0] doubled_median(input int unsigned len);
    int unsigned hi_rank, lo_rank, running, hi_bin, lo_bin, total;
    bit hi_found, lo_found;
    hi_rank  = len / 2 + 1;
    lo_rank  = len / 2;
    running  = 0;
    hi_bin   = 0;
    lo_bin   = 0;
    hi_found = 0;
    lo_found = 0;
    for (int b = 0; b < BINS; b++) begin
      running += bin_count[b];
      if (!hi_found && running >= hi_rank) begin
        hi_bin   = b;
        hi_found = 1;
      end
      if (!lo_found && running >= lo_rank) begin
        lo_bin   = b;
        lo_found = 1;
      end
    end
    total = (len % 2 != 0) ? 2 * hi_bin : hi_bin + lo_bin;
    if (total > 511) total = 511;
    return total[DBL_W-1:0];
  endfunction

  // Work out the result word for one accepted sample and update the window.
  task automatic window_step(input logic [VAL_W-1:0] v, output spike_word_t w);
    int unsigned len;
    bit          full;
    len  = active_length();
    full = (fill >= len);
    w    = '0;
    if (full) begin
      w.med2 = doubled_median(len);
      if ({1'b0, v} >= w.med2) begin
        w.alert = 1'b1;
        if (alerts != CNT_MAX) alerts++;
      end
    end
    if (ring_pos >= len) ring_pos = 0;
    if (full) begin
      if (bin_count[ring[ring_pos]] != 0) bin_count[ring[ring_pos]]--;
    end else begin
      fill++;
    end
    ring[ring_pos] = v;
    if (bin_count[v] != 9'h1FF) bin_count[v]++;
    ring_pos++;
    if (ring_pos >= len) ring_pos = 0;
    w.full  = full;
    w.count = alerts;
  endtask

  function automatic row_t smp(input logic [VAL_W-1:0] v);
    row_t r;
    r       = '0;
    r.kind  = ROW_SAMPLE;
    r.value = {1'b0, v};
    return r;
  endfunction

  function automatic row_t smp_pin(input logic [VAL_W-1:0] v, input logic a,
                                   input logic f, input logic [DBL_W-1:0] m,
                                   input logic [CNT_W-1:0] c);
    row_t r;
    r            = smp(v);
    r.pinned     = 1'b1;
    r.word.alert = a;
    r.word.full  = f;
    r.word.med2  = m;
    r.word.count = c;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [LEN_W-1:0] v);
    row_t r;
    r       = '0;
    r.kind  = ROW_CONFIG;
    r.value = v;
    return r;
  endfunction

  // Mostly small values so the median stays low, with spikes and extremes.
  function automatic logic [VAL_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return VAL_W'($urandom_range(0, 31));
    if (pick < 80) return VAL_W'($urandom_range(0, 255));
    if (pick < 90) return VAL_W'($urandom_range(128, 255));
    return pick[0] ? {VAL_W{1'b1}} : '0;
  endfunction

  // Offer one sample word and hold it until the block takes it.
  task automatic send_sample(input logic [VAL_W-1:0] v, input logic pinned,
                             input spike_word_t w);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    pin_on       <= pinned;
    pin_word     <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write the window length once the block has drained.
  task automatic write_length(input logic [LEN_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid     <= 1'b1;
    window_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endtask

  // Follow every handshake: update the model on config and sample words,
  // and check each result word against the oldest expectation.
  always @(posedge clk) begin : monitor
    spike_word_t w;
    spike_word_t got;
    bit          moved;
    if (!rst) begin
      moved = 0;
      if (cfg_valid && cfg_ready) begin
        len_reg = window_length;
        window_clear();
        moved = 1;
      end
      if (in_valid && in_ready) begin
        window_step(sample_value, w);
        if (pin_on) w = pin_word;
        expected_words = {expected_words, w};
        moved = 1;
      end
      if (out_valid && out_ready) begin
        moved     = 1;
        got.alert = alert;
        got.full  = window_full;
        got.med2  = median_doubled;
        got.count = alert_count;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, got %0h", $time, got);
        end else begin
          w = expected_words.pop_front();
          check_field("alert", 32'(w.alert), 32'(got.alert));
          check_field("window_full", 32'(w.full), 32'(got.full));
          check_field("median_doubled", 32'(w.med2), 32'(got.med2));
          check_field("alert_count", 32'(w.count), 32'(got.count));
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Result side: random back-pressure plus one long hold-off.
  initial begin : receiver
    int hold;
    int seen;
    bit held;
    hold      = 0;
    seen      = 0;
    held      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) seen++;
      if (!held && seen >= HOLD_AFTER) begin
        held = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin : watchdog
    stall_cycles = 0;
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int          phase_len [N_PHASES];
    int          phase_items [N_PHASES];
    logic [LEN_W-1:0] len_v;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    window_length = '0;
    in_valid      = 1'b0;
    sample_value  = '0;
    pin_on        = 1'b0;
    pin_word      = '0;
    quiet         = 0;
    mismatches    = 0;
    len_reg       = LEN_W'(5);
    alerts        = '0;
    window_clear();
    phase_len   = '{5, 3, 4, 256, 1, 8, -1};
    phase_items = '{150, 150, 150, 400, 100, 150, 200};

    // Directed words: fill after reset, extremes, length zero and above the
    // maximum, an even window, a rewrite of the same length, the longest window.
    script = '{
      smp_pin(8'd255, 1'b0, 1'b0, '0, '0),
      smp_pin(8'd0,   1'b0, 1'b0, '0, '0),
      smp_pin(8'd255, 1'b0, 1'b0, '0, '0),
      smp_pin(8'd0,   1'b0, 1'b0, '0, '0),
      smp_pin(8'd128, 1'b0, 1'b0, '0, '0),
      smp(8'd0), smp(8'd255),
      cfg_row(9'd0), smp(8'd7), smp(8'd0), smp(8'd0),
      cfg_row(9'd511), smp(8'd200), smp(8'd0),
      cfg_row(9'd2), smp(8'd10), smp(8'd20), smp(8'd15), smp(8'd255),
      cfg_row(9'd2), smp(8'd0), smp(8'd0), smp(8'd0),
      cfg_row(9'd256), smp(8'd1)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      if (script[i].kind == ROW_CONFIG) begin
        write_length(script[i].value);
      end else begin
        send_sample(script[i].value[VAL_W-1:0], script[i].pinned, script[i].word);
      end
    end

    // Random phases; the longest window runs with no random idling on either side.
    for (int p = 0; p < N_PHASES; p++) begin
      len_v = (phase_len[p] < 0) ? LEN_W'($urandom_range(0, 511)) : LEN_W'(phase_len[p]);
      write_length(len_v);
      quiet = (phase_len[p] == WINDOW_MAX);
      for (int n = 0; n < phase_items[p]; n++) send_sample(random_sample(), 1'b0, '0);
      quiet = 0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/smsd_pkg.sv
hw/rtl/smsd_cell.sv
hw/rtl/smsd_chain.sv
hw/rtl/sliding_median_spike_detector.sv
dv/tb_top.sv
